// File: design/scc_pkg.sv
package scc_pkg;

  // Calendar constants.
  localparam int unsigned ERA_OFFSET     = 78;
  localparam int unsigned YEAR_START_DAY = 80;
  localparam int unsigned MAX_YEAR       = 9999;
  localparam int unsigned JDN_EPOCH      = 32045;
  localparam int unsigned JDN_YEAR_SHIFT = 4800;
  localparam int unsigned LONG_MONTHS    = 31 * 5;
  localparam int unsigned SHORT_TAIL     = 30 * 3;
  localparam int unsigned LEAP_START_DAY = 21;
  localparam int unsigned NORM_START_DAY = 22;

  // Reciprocal of 25 scaled by 2^16, rounded down so that the estimate never overshoots.
  localparam int unsigned DIV25_RECIP = 2621;

  // Conversion kinds.
  typedef enum logic {
    KIND_GREG_TO_SAKA = 1'b0,
    KIND_SAKA_TO_JDN  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [14:0] civil_year;
    logic [14:0] yy;
    logic        range_ok;
  } scc_dec_t;

  typedef struct packed {
    scc_dec_t    dec;
    logic        leap;
    logic        leap_prev;
    logic [12:0] q4;
    logic [7:0]  q100;
  } scc_leap_t;

  typedef struct packed {
    kind_t       kind;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        ok;
    logic [13:0] saka_year;
    logic        chaitra_long;
    logic [8:0]  yday;
    logic [22:0] jbase;
  } scc_mid_t;

  typedef struct packed {
    logic [13:0] saka_year;
    logic [3:0]  saka_month;
    logic [4:0]  saka_day;
    logic [22:0] julian_day;
    logic        valid_res;
  } scc_res_t;

  // Quotient by 25 through a reciprocal multiply and one correction step.
  function automatic logic [10:0] div25(input logic [14:0] x);
    logic [26:0] prod;
    logic [10:0] q;
    logic [14:0] r;
    prod = 27'(x) * 27'(DIV25_RECIP);
    q    = prod[26:16];
    r    = x - 15'(15'(q) * 15'd25);
    if (r >= 15'd25) begin
      q = q + 11'd1;
    end
    return q;
  endfunction

  // Gregorian leap rule; a multiple of 4 is a century only when y/4 is a multiple of 25.
  function automatic logic is_leap(input logic [14:0] y);
    logic [10:0] q;
    logic        not_century;
    q           = div25(15'(y[14:2]));
    not_century = (15'(y[14:2]) != 15'(15'(q) * 15'd25));
    return (y[1:0] == 2'd0) && (not_century || (y[3:0] == 4'd0));
  endfunction

  // Length of a Gregorian month in a common year.
  function automatic logic [4:0] greg_len(input logic [3:0] m);
    logic [4:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      4'd2:                                      len = 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

  // Days before a Gregorian month in a common year.
  function automatic logic [8:0] greg_cum(input logic [3:0] m);
    logic [8:0] c;
    unique case (m)
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

  // Days before a Saka month when Chaitra has 30 days.
  function automatic logic [8:0] saka_cum(input logic [3:0] m);
    logic [8:0] c;
    unique case (m)
      4'd2:    c = 9'd30;
      4'd3:    c = 9'd61;
      4'd4:    c = 9'd92;
      4'd5:    c = 9'd123;
      4'd6:    c = 9'd154;
      4'd7:    c = 9'd185;
      4'd8:    c = 9'd215;
      4'd9:    c = 9'd245;
      4'd10:   c = 9'd275;
      4'd11:   c = 9'd305;
      4'd12:   c = 9'd335;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

  // Month term of the day number, (153 * mm + 2) / 5 with the year starting in March.
  function automatic logic [8:0] jdn_month(input logic [3:0] m);
    logic [8:0] c;
    unique case (m)
      4'd1:    c = 9'd306;
      4'd2:    c = 9'd337;
      4'd4:    c = 9'd31;
      4'd5:    c = 9'd61;
      4'd6:    c = 9'd92;
      4'd7:    c = 9'd122;
      4'd8:    c = 9'd153;
      4'd9:    c = 9'd184;
      4'd10:   c = 9'd214;
      4'd11:   c = 9'd245;
      4'd12:   c = 9'd275;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

endpackage

// File: design/scc_decode.sv
module scc_decode (
  input  logic                clk,
  input  logic                load,
  input  logic                kind,
  input  logic [13:0]         in_year,
  input  logic [3:0]          in_month,
  input  logic [4:0]          in_day,
  output scc_pkg::scc_dec_t   q
);

  scc_pkg::scc_dec_t q_next;
  logic              march_shift;

  // Range checks and the Gregorian year whose day number is wanted.
  always_comb begin
    q_next.kind       = scc_pkg::kind_t'(kind);
    q_next.year       = in_year;
    q_next.month      = in_month;
    q_next.day        = in_day;
    q_next.range_ok   = (in_year >= 14'd1) && (in_year <= 14'(scc_pkg::MAX_YEAR)) &&
                        (in_month >= 4'd1) && (in_month <= 4'd12) && (in_day >= 5'd1);
    q_next.civil_year = kind ? (15'(in_year) + 15'(scc_pkg::ERA_OFFSET)) : 15'(in_year);
    // January and February count as months of the previous year.
    march_shift       = !kind && (in_month <= 4'd2);
    q_next.yy         = q_next.civil_year + 15'(scc_pkg::JDN_YEAR_SHIFT) - 15'(march_shift);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= q_next;
    end
  end

endmodule

// File: design/scc_leap.sv
module scc_leap (
  input  logic               clk,
  input  logic               load,
  input  scc_pkg::scc_dec_t  d,
  output scc_pkg::scc_leap_t q
);

  scc_pkg::scc_leap_t q_next;
  logic [10:0]        q100_full;

  // Leap flags for this year and the one before, and the century count for the day number.
  always_comb begin
    q_next.dec       = d;
    q_next.leap      = scc_pkg::is_leap(d.civil_year);
    q_next.leap_prev = scc_pkg::is_leap(15'(d.year) - 15'd1);
    q_next.q4        = d.yy[14:2];
    q100_full        = scc_pkg::div25(15'(d.yy[14:2]));
    q_next.q100      = q100_full[7:0];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= q_next;
    end
  end

endmodule

// File: design/scc_yday.sv
module scc_yday (
  input  logic                clk,
  input  logic                load,
  input  scc_pkg::scc_leap_t  d,
  output scc_pkg::scc_mid_t   q
);

  scc_pkg::scc_mid_t q_next;
  logic [4:0]        day_term;
  logic [8:0]        month_term;
  logic [23:0]       jsum;
  logic [4:0]        glen;
  logic [4:0]        slen;
  logic [8:0]        yday_greg;
  logic [8:0]        yday_saka;
  logic              before_new_year;
  logic              greg_ok;
  logic              saka_ok;

  always_comb begin
    // Day number of the Gregorian date; for a Saka date, that of Chaitra 1.
    day_term   = (d.dec.kind == scc_pkg::KIND_SAKA_TO_JDN) ?
                 (d.leap ? 5'(scc_pkg::LEAP_START_DAY) : 5'(scc_pkg::NORM_START_DAY)) :
                 d.dec.day;
    month_term = (d.dec.kind == scc_pkg::KIND_SAKA_TO_JDN) ? 9'd0 :
                 scc_pkg::jdn_month(d.dec.month);
    jsum = 24'(d.dec.yy) * 24'd365 + 24'(d.q4) + 24'(d.q100[7:2]) + 24'(month_term) +
           24'(day_term) - 24'(d.q100) - 24'(scc_pkg::JDN_EPOCH);

    // Gregorian day of year and its place in the Saka year.
    glen            = scc_pkg::greg_len(d.dec.month) + 5'((d.dec.month == 4'd2) && d.leap);
    yday_greg       = scc_pkg::greg_cum(d.dec.month) + 9'((d.dec.month > 4'd2) && d.leap) +
                      9'(d.dec.day) - 9'd1;
    before_new_year = (yday_greg < 9'(scc_pkg::YEAR_START_DAY));
    greg_ok         = (d.dec.day <= glen) &&
                      (before_new_year ? (d.dec.year >= 14'(scc_pkg::ERA_OFFSET + 1)) :
                                         (d.dec.year >= 14'(scc_pkg::ERA_OFFSET)));

    // Saka month lengths and days before the Saka date.
    if (d.dec.month == 4'd1) begin
      slen = 5'd30 + 5'(d.leap);
    end else if (d.dec.month <= 4'd6) begin
      slen = 5'd31;
    end else begin
      slen = 5'd30;
    end
    saka_ok   = (d.dec.day <= slen);
    yday_saka = scc_pkg::saka_cum(d.dec.month) + 9'((d.dec.month > 4'd1) && d.leap) +
                9'(d.dec.day) - 9'd1;

    q_next.kind  = d.dec.kind;
    q_next.year  = d.dec.year;
    q_next.month = d.dec.month;
    q_next.day   = d.dec.day;
    q_next.jbase = jsum[22:0];
    if (d.dec.kind == scc_pkg::KIND_SAKA_TO_JDN) begin
      q_next.ok           = d.dec.range_ok && saka_ok;
      q_next.saka_year    = d.dec.year;
      q_next.chaitra_long = d.leap;
      q_next.yday         = yday_saka;
    end else if (before_new_year) begin
      // The date belongs to the Saka year that began in the previous Gregorian year.
      q_next.ok           = d.dec.range_ok && greg_ok;
      q_next.saka_year    = d.dec.year - 14'(scc_pkg::ERA_OFFSET + 1);
      q_next.chaitra_long = d.leap_prev;
      q_next.yday         = yday_greg + 9'd30 + 9'(d.leap_prev) +
                            9'(scc_pkg::LONG_MONTHS + scc_pkg::SHORT_TAIL + 10);
    end else begin
      q_next.ok           = d.dec.range_ok && greg_ok;
      q_next.saka_year    = d.dec.year - 14'(scc_pkg::ERA_OFFSET);
      q_next.chaitra_long = d.leap;
      q_next.yday         = yday_greg - 9'(scc_pkg::YEAR_START_DAY);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= q_next;
    end
  end

endmodule

// File: design/scc_split.sv
module scc_split (
  input  logic               clk,
  input  logic               load,
  input  scc_pkg::scc_mid_t  d,
  output scc_pkg::scc_res_t  q
);

  scc_pkg::scc_res_t q_next;
  logic [8:0]        chaitra_len;
  logic [8:0]        md;
  logic [8:0]        md_tail;
  logic [2:0]        q31;
  logic [2:0]        q30;
  logic [3:0]        sm;
  logic [8:0]        sd;

  always_comb begin
    // Split the Saka day of year into month and day; short month groups by comparison.
    chaitra_len = 9'd30 + 9'(d.chaitra_long);
    md          = d.yday - chaitra_len;
    md_tail     = md - 9'(scc_pkg::LONG_MONTHS);
    if (md >= 9'd124) begin
      q31 = 3'd4;
    end else if (md >= 9'd93) begin
      q31 = 3'd3;
    end else if (md >= 9'd62) begin
      q31 = 3'd2;
    end else if (md >= 9'd31) begin
      q31 = 3'd1;
    end else begin
      q31 = 3'd0;
    end
    if (md_tail >= 9'd150) begin
      q30 = 3'd5;
    end else if (md_tail >= 9'd120) begin
      q30 = 3'd4;
    end else if (md_tail >= 9'd90) begin
      q30 = 3'd3;
    end else if (md_tail >= 9'd60) begin
      q30 = 3'd2;
    end else if (md_tail >= 9'd30) begin
      q30 = 3'd1;
    end else begin
      q30 = 3'd0;
    end

    if (d.yday < chaitra_len) begin
      sm = 4'd1;
      sd = d.yday + 9'd1;
    end else if (md < 9'(scc_pkg::LONG_MONTHS)) begin
      sm = 4'(q31) + 4'd2;
      sd = md - 9'(9'(q31) * 9'd31) + 9'd1;
    end else begin
      sm = 4'(q30) + 4'd7;
      sd = md_tail - 9'(9'(q30) * 9'd30) + 9'd1;
    end

    // Invalid dates give all-zero fields.
    q_next = '0;
    if (d.ok) begin
      q_next.valid_res = 1'b1;
      q_next.saka_year = d.saka_year;
      if (d.kind == scc_pkg::KIND_SAKA_TO_JDN) begin
        q_next.saka_month = d.month;
        q_next.saka_day   = d.day;
        q_next.julian_day = d.jbase + 23'(d.yday);
      end else begin
        q_next.saka_month = sm;
        q_next.saka_day   = sd[4:0];
        q_next.julian_day = d.jbase;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= q_next;
    end
  end

endmodule

// File: design/saka_calendar_converter.sv
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   kind, in_year, in_month, in_day
// out       output     out_valid / out_stall saka_year, saka_month, saka_day, julian_day,
//                                            valid_res
//
// Four register stages: decode, leap and century terms, day of year with the day
// number, and month split into the output register.
// One item is taken every cycle while out_stall is low.
// Reset clears the stage valid bits only; payload registers are not reset.
// A stall holds the output register and lets bubbles behind it close up, so the
// pipeline keeps up to four items while the output side waits.
module saka_calendar_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [13:0] in_year,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_day,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [13:0] saka_year,
  output logic [3:0]  saka_month,
  output logic [4:0]  saka_day,
  output logic [22:0] julian_day,
  output logic        valid_res
);

  scc_pkg::scc_dec_t  dec_q;
  scc_pkg::scc_leap_t leap_q;
  scc_pkg::scc_mid_t  mid_q;
  scc_pkg::scc_res_t  res_q;

  logic dec_valid;
  logic leap_valid;
  logic mid_valid;
  logic res_ready;
  logic mid_ready;
  logic leap_ready;
  logic dec_ready;

  // A stage can load when it is empty or the stage after it moves on.
  assign res_ready  = !out_valid || !out_stall;
  assign mid_ready  = !mid_valid || res_ready;
  assign leap_ready = !leap_valid || mid_ready;
  assign dec_ready  = !dec_valid || leap_ready;
  assign in_stall   = !dec_ready;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid  <= 1'b0;
      leap_valid <= 1'b0;
      mid_valid  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (dec_ready) begin
        dec_valid <= in_valid;
      end
      if (leap_ready) begin
        leap_valid <= dec_valid;
      end
      if (mid_ready) begin
        mid_valid <= leap_valid;
      end
      if (res_ready) begin
        out_valid <= mid_valid;
      end
    end
  end

  scc_decode u_decode (
    .clk      (clk),
    .load     (in_valid && dec_ready),
    .kind     (kind),
    .in_year  (in_year),
    .in_month (in_month),
    .in_day   (in_day),
    .q        (dec_q)
  );

  scc_leap u_leap (
    .clk  (clk),
    .load (dec_valid && leap_ready),
    .d    (dec_q),
    .q    (leap_q)
  );

  scc_yday u_yday (
    .clk  (clk),
    .load (leap_valid && mid_ready),
    .d    (leap_q),
    .q    (mid_q)
  );

  scc_split u_split (
    .clk  (clk),
    .load (mid_valid && res_ready),
    .d    (mid_q),
    .q    (res_q)
  );

  assign saka_year  = res_q.saka_year;
  assign saka_month = res_q.saka_month;
  assign saka_day   = res_q.saka_day;
  assign julian_day = res_q.julian_day;
  assign valid_res  = res_q.valid_res;

  // An accepted item always lands in the first stage.
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> dec_valid)
    else $error("accepted item did not reach the decode stage");

  // With the output side free the whole pipeline advances.
  a_no_stall_free: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while the output side was free");

  // A full pipeline behind a stalled output must hold off the input.
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    dec_valid && leap_valid && mid_valid && out_valid && out_stall |-> in_stall)
    else $error("item taken into a full pipeline");

  // Invalid dates carry zero fields.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> saka_year == 14'd0 && saka_month == 4'd0 &&
                                saka_day == 5'd0 && julian_day == 23'd0)
    else $error("invalid result with non-zero fields");

  // Valid results name a real Saka month and day.
  a_valid_month: assert property (@(posedge clk) disable iff (rst)
    out_valid && valid_res |-> saka_month >= 4'd1 && saka_month <= 4'd12 &&
                               saka_day >= 5'd1 && saka_day <= 5'd31)
    else $error("valid result outside the Saka month range");

endmodule

// File: dv/saka_checker.sv
`timescale 1ns / 1ps

module saka_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        kind,
  input  logic [13:0] in_year,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_day,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [13:0] saka_year,
  input  logic [3:0]  saka_month,
  input  logic [4:0]  saka_day,
  input  logic [22:0] julian_day,
  input  logic        valid_res,
  output int          mismatches,
  output int          pending
);

  // Converted dates still owed by the block, oldest first.
  scc_pkg::scc_res_t expected_dates[$];
  int                fail_count = 0;

  assign mismatches = fail_count;

  function automatic bit leap_year(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int greg_month_len(input int m, input bit leap);
    int len;
    case (m)
      2:             len = leap ? 29 : 28;
      4, 6, 9, 11:   len = 30;
      default:       len = 31;
    endcase
    return len;
  endfunction

  // Day number of a proleptic Gregorian date, with the year counted from March.
  function automatic int day_number(input int y, input int m, input int d);
    int a;
    int yy;
    int mm;
    a  = (14 - m) / 12;
    yy = y + int'(scc_pkg::JDN_YEAR_SHIFT) - a;
    mm = m + 12 * a - 3;
    return d + (153 * mm + 2) / 5 + 365 * yy + yy / 4 - yy / 100 + yy / 400
           - int'(scc_pkg::JDN_EPOCH);
  endfunction

  // Expected result of one item; an impossible or out-of-range date gives all zeros.
  function automatic scc_pkg::scc_res_t convert_date(input logic k, input logic [13:0] yr,
                                                     input logic [3:0] mo,
                                                     input logic [4:0] dy);
    scc_pkg::scc_res_t r;
    int       y;
    int       m;
    int       d;
    int       i;
    int       yday;
    int       chaitra;
    int       syear;
    int       md;
    int       gy;
    int       t;
    int       span;
    bit       leap;
    r = '0;
    y = int'(yr);
    m = int'(mo);
    d = int'(dy);
    if (y < 1 || y > int'(scc_pkg::MAX_YEAR) || m < 1 || m > 12 || d < 1) begin
      return r;
    end
    if (scc_pkg::kind_t'(k) == scc_pkg::KIND_GREG_TO_SAKA) begin
      leap = leap_year(y);
      if (d > greg_month_len(m, leap)) begin
        return r;
      end
      yday = d - 1;
      for (i = 1; i < m; i++) begin
        yday += greg_month_len(i, leap);
      end
      // Before the new year the date belongs to the Saka year begun last spring.
      if (yday < int'(scc_pkg::YEAR_START_DAY)) begin
        syear   = y - int'(scc_pkg::ERA_OFFSET) - 1;
        chaitra = leap_year(y - 1) ? 31 : 30;
        yday   += chaitra + int'(scc_pkg::LONG_MONTHS) + int'(scc_pkg::SHORT_TAIL) + 10;
      end else begin
        syear   = y - int'(scc_pkg::ERA_OFFSET);
        chaitra = leap ? 31 : 30;
        yday   -= int'(scc_pkg::YEAR_START_DAY);
      end
      if (syear < 0) begin
        return r;
      end
      // Split the day of the Saka year into month and day.
      if (yday < chaitra) begin
        r.saka_month = 4'd1;
        r.saka_day   = 5'(yday + 1);
      end else begin
        md = yday - chaitra;
        if (md < int'(scc_pkg::LONG_MONTHS)) begin
          r.saka_month = 4'(md / 31 + 2);
          r.saka_day   = 5'(md % 31 + 1);
        end else begin
          md -= int'(scc_pkg::LONG_MONTHS);
          r.saka_month = 4'(md / 30 + 7);
          r.saka_day   = 5'(md % 30 + 1);
        end
      end
      r.saka_year  = 14'(syear);
      t            = day_number(y, m, d);
      r.julian_day = t[22:0];
    end else begin
      gy      = y + int'(scc_pkg::ERA_OFFSET);
      leap    = leap_year(gy);
      chaitra = leap ? 31 : 30;
      if (m == 1) begin
        span = chaitra;
      end else begin
        span = (m <= 6) ? 31 : 30;
      end
      if (d > span) begin
        return r;
      end
      // Count forward from Chaitra 1 in the matching Gregorian year.
      t = day_number(gy, 3, leap ? int'(scc_pkg::LEAP_START_DAY) :
                                   int'(scc_pkg::NORM_START_DAY));
      if (m > 1) begin
        md = (m - 2 > 5) ? 5 : m - 2;
        t += chaitra + md * 31;
        if (m >= 8) begin
          t += (m - 7) * 30;
        end
      end
      t           += d - 1;
      r.saka_year  = yr;
      r.saka_month = mo;
      r.saka_day   = dy;
      r.julian_day = t[22:0];
    end
    r.valid_res = 1'b1;
    return r;
  endfunction

  // Retire the outgoing item before queueing the incoming one.
  always @(posedge clk) begin
    scc_pkg::scc_res_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_dates.size() == 0) begin
          if (fail_count < 10) begin
            $display("unexpected item: y=%0d m=%0d d=%0d jd=%0d ok=%0d",
                     saka_year, saka_month, saka_day, julian_day, valid_res);
          end
          fail_count++;
        end else begin
          want = expected_dates.pop_front();
          if (saka_year !== want.saka_year || saka_month !== want.saka_month ||
              saka_day !== want.saka_day || julian_day !== want.julian_day ||
              valid_res !== want.valid_res) begin
            if (fail_count < 10) begin
              $display("mismatch: expected y=%0d m=%0d d=%0d jd=%0d ok=%0d",
                       want.saka_year, want.saka_month, want.saka_day,
                       want.julian_day, want.valid_res);
              $display("          actual   y=%0d m=%0d d=%0d jd=%0d ok=%0d",
                       saka_year, saka_month, saka_day, julian_day, valid_res);
            end
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_dates.push_back(convert_date(kind, in_year, in_month, in_day));
      end
    end
    pending <= expected_dates.size();
  end

endmodule

// File: dv/tb_saka_calendar_converter.sv
`timescale 1ns / 1ps

module tb_saka_calendar_converter;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        kind;
  logic [13:0] in_year;
  logic [3:0]  in_month;
  logic [4:0]  in_day;
  logic        out_valid;
  logic        out_stall;
  logic [13:0] saka_year;
  logic [3:0]  saka_month;
  logic [4:0]  saka_day;
  logic [22:0] julian_day;
  logic        valid_res;
  int          mismatches;
  int          pending;

  // Set for stretches in which neither side inserts idle cycles.
  bit          no_gaps = 1'b0;

  saka_calendar_converter i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .in_year    (in_year),
    .in_month   (in_month),
    .in_day     (in_day),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .saka_year  (saka_year),
    .saka_month (saka_month),
    .saka_day   (saka_day),
    .julian_day (julian_day),
    .valid_res  (valid_res)
  );

  saka_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .in_year    (in_year),
    .in_month   (in_month),
    .in_day     (in_day),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .saka_year  (saka_year),
    .saka_month (saka_month),
    .saka_day   (saka_day),
    .julian_day (julian_day),
    .valid_res  (valid_res),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2400000;
    $display("TB_ERROR");
    $finish;
  end

  // Offer one date and hold it until the block takes it.
  task automatic offer_date(input scc_pkg::kind_t k, input int y, input int m, input int d);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    in_year  <= 14'(y);
    in_month <= 4'(m);
    in_day   <= 5'(d);
    do @(posedge clk); while (in_stall);
  endtask

  // Receiving side: random stalls per item, and one long hold-off to back the block up.
  initial begin
    int wait_cycles;
    int taken;
    out_stall <= 1'b1;
    taken = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (taken == 300) begin
        wait_cycles = 100;
      end else begin
        wait_cycles = no_gaps ? 0 : $urandom_range(0, 3);
      end
      if (wait_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin
    scc_pkg::kind_t k;
    int    y;
    int    m;
    int    d;
    int    n;
    in_valid <= 1'b0;
    kind     <= scc_pkg::KIND_GREG_TO_SAKA;
    in_year  <= '0;
    in_month <= '0;
    in_day   <= '0;
    rst      <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Gregorian dates: new year edges, early years, leap days and malformed fields.
    offer_date(scc_pkg::KIND_GREG_TO_SAKA, 2000, 3, 20);
    offer_date(scc_pkg::KIND_GREG_TO_SAKA, 2000, 3, 21);
    offer_date(scc_pkg::KIND_GREG_TO_SAKA, 2001, 3, 21);
    offer_date(scc_pkg::KIND_GREG_TO_SAKA, 2001, 3, 22);
    offer_date(scc_pkg::KIND_GREG_TO_SAKA, 78, 3, 22);
    offer_date(scc_pkg::KIND_GREG_TO_SAKA, 78, 3, 21);
    offer_date(scc_pkg::KIND_GREG_TO_SAKA, 1, 1, 1);
    offer_date(scc_pkg::KIND_GREG_TO_SAKA, 9999, 12, 31);
    offer_date(scc_pkg::KIND_GREG_TO_SAKA, 1582, 10, 10);
    offer_date(scc_pkg::KIND_GREG_TO_SAKA, 1900, 2, 29);
    offer_date(scc_pkg::KIND_GREG_TO_SAKA, 2000, 2, 29);
    offer_date(scc_pkg::KIND_GREG_TO_SAKA, 2023, 4, 31);
    offer_date(scc_pkg::KIND_GREG_TO_SAKA, 0, 5, 5);
    offer_date(scc_pkg::KIND_GREG_TO_SAKA, 16383, 15, 31);
    offer_date(scc_pkg::KIND_GREG_TO_SAKA, 2024, 0, 0);
    offer_date(scc_pkg::KIND_GREG_TO_SAKA, 2024, 13, 1);
    // Saka dates: long and short Chaitra, month length edges and malformed fields.
    offer_date(scc_pkg::KIND_SAKA_TO_JDN, 1, 1, 1);
    offer_date(scc_pkg::KIND_SAKA_TO_JDN, 9999, 12, 30);
    offer_date(scc_pkg::KIND_SAKA_TO_JDN, 9999, 12, 31);
    offer_date(scc_pkg::KIND_SAKA_TO_JDN, 1922, 1, 31);
    offer_date(scc_pkg::KIND_SAKA_TO_JDN, 1923, 1, 31);
    offer_date(scc_pkg::KIND_SAKA_TO_JDN, 1945, 6, 31);
    offer_date(scc_pkg::KIND_SAKA_TO_JDN, 1945, 7, 31);
    offer_date(scc_pkg::KIND_SAKA_TO_JDN, 1945, 7, 30);
    offer_date(scc_pkg::KIND_SAKA_TO_JDN, 0, 0, 0);
    offer_date(scc_pkg::KIND_SAKA_TO_JDN, 16383, 13, 1);

    // Random dates, mostly well formed, with a share of boundary years and bad fields.
    for (n = 0; n < 800; n++) begin
      if (n % 40 == 0) begin
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      k = scc_pkg::kind_t'($urandom_range(0, 1));
      case ($urandom_range(0, 15))
        0:       y = $urandom_range(0, 16383);
        1:       y = $urandom_range(70, 82);
        2:       y = $urandom_range(9990, 9999);
        default: y = $urandom_range(1, 9999);
      endcase
      m = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
      d = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 31);
      if (k == scc_pkg::KIND_GREG_TO_SAKA && $urandom_range(0, 7) == 0) begin
        m = 3;
        d = $urandom_range(19, 23);
      end
      offer_date(k, y, m, d);
    end
    in_valid <= 1'b0;

    // Let the last item reach the checker, then drain the pipeline.
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/scc_pkg.sv
design/scc_decode.sv
design/scc_leap.sv
design/scc_yday.sv
design/scc_split.sv
design/saka_calendar_converter.sv
dv/saka_checker.sv
dv/tb_saka_calendar_converter.sv
